>>> hw/rtl/sbbvm_pkg.sv
// Shared constants and types for the sparse byte buffer with valid map.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbbvm_pkg;

    localparam int CMD_W  = 3;
    localparam int OFF_W  = 12;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 13;
    localparam int RES_W  = 13;
    localparam int EMIT_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_WRITE        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ         = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT_VALID   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT_INVALID = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RUN_LENGTH   = 3'd5;

    // Kind of result word that the controller asks the datapath to produce.
    localparam logic [EMIT_W-1:0] EMIT_NONE = 3'd0;
    localparam logic [EMIT_W-1:0] EMIT_ZERO = 3'd1;
    localparam logic [EMIT_W-1:0] EMIT_ERR  = 3'd2;
    localparam logic [EMIT_W-1:0] EMIT_READ = 3'd3;
    localparam logic [EMIT_W-1:0] EMIT_HIT  = 3'd4;
    localparam logic [EMIT_W-1:0] EMIT_END  = 3'd5;
    localparam logic [EMIT_W-1:0] EMIT_OOR  = 3'd6;

    typedef struct packed {
        logic              capture;
        logic              clear_map;
        logic              wr_commit;
        logic              step;
        logic [EMIT_W-1:0] emit;
    } t_ctl;

    typedef struct packed {
        logic in_range;
        logic hit;
        logic last;
    } t_sts;

endpackage

`default_nettype wire

>>> hw/rtl/sbbvm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the byte store and the valid map rows.
`default_nettype none

module sbbvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/sbbvm_ctrl.sv
// Command sequencer for the sparse byte buffer.
// Depends on sbbvm_pkg for command codes and the control and status structs.
`default_nettype none

module sbbvm_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sbbvm_pkg::CMD_W-1:0] i_command,
    input  wire sbbvm_pkg::t_sts             i_sts,
    output logic                             o_busy,
    output sbbvm_pkg::t_ctl                  o_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WR   = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.capture = 1'b1;
                    unique case (i_command)
                        sbbvm_pkg::CMD_WRITE: begin
                            if (i_sts.in_range) begin
                                n_state = ST_WR;
                            end else begin
                                o_ctl.emit = sbbvm_pkg::EMIT_ERR;
                            end
                        end
                        sbbvm_pkg::CMD_CLEAR: begin
                            o_ctl.clear_map = 1'b1;
                            o_ctl.emit      = sbbvm_pkg::EMIT_ZERO;
                        end
                        sbbvm_pkg::CMD_READ: begin
                            if (i_sts.in_range) begin
                                n_state = ST_RD;
                            end else begin
                                o_ctl.emit = sbbvm_pkg::EMIT_ERR;
                            end
                        end
                        sbbvm_pkg::CMD_NEXT_VALID,
                        sbbvm_pkg::CMD_NEXT_INVALID,
                        sbbvm_pkg::CMD_RUN_LENGTH: begin
                            if (i_sts.in_range) begin
                                n_state = ST_SCAN;
                            end else begin
                                o_ctl.emit = sbbvm_pkg::EMIT_OOR;
                            end
                        end
                        default: begin
                            o_ctl.emit = sbbvm_pkg::EMIT_ZERO;
                        end
                    endcase
                end
            end
            ST_WR: begin
                o_ctl.wr_commit = 1'b1;
                o_ctl.emit      = sbbvm_pkg::EMIT_ZERO;
                n_state         = ST_IDLE;
            end
            ST_RD: begin
                o_ctl.emit = sbbvm_pkg::EMIT_READ;
                n_state    = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    o_ctl.emit = sbbvm_pkg::EMIT_HIT;
                    n_state    = ST_IDLE;
                end else if (i_sts.last) begin
                    o_ctl.emit = sbbvm_pkg::EMIT_END;
                    n_state    = ST_IDLE;
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> (o_ctl.emit != sbbvm_pkg::EMIT_NONE) || (n_state != ST_IDLE))
        else $error("Accepted word neither answered nor started.");
    a_return_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && n_state == ST_IDLE) |-> (o_ctl.emit != sbbvm_pkg::EMIT_NONE))
        else $error("Command finished without a result word.");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sbbvm_dp.sv
// Datapath of the sparse byte buffer: size register, valid map rows, byte store,
// scan logic and result registers. Depends on sbbvm_pkg and sbbvm_ram.
`default_nettype none

module sbbvm_dp #(
    parameter int DEPTH          = 4096,
    parameter int SCAN_WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sbbvm_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  wire logic [sbbvm_pkg::CMD_W-1:0]  i_command,
    input  wire logic [sbbvm_pkg::OFF_W-1:0]  i_offset,
    input  wire logic [sbbvm_pkg::BYTE_W-1:0] i_write_byte,
    input  wire sbbvm_pkg::t_ctl              i_ctl,
    output sbbvm_pkg::t_sts                   o_sts,
    output logic                              o_done,
    output logic                              o_status,
    output logic [sbbvm_pkg::RES_W-1:0]       o_found_offset,
    output logic [sbbvm_pkg::RES_W-1:0]       o_run_length,
    output logic [sbbvm_pkg::BYTE_W-1:0]      o_read_byte,
    output logic                              o_is_valid
);

    localparam int LW    = (SCAN_WORD_BITS > 1) ? $clog2(SCAN_WORD_BITS) : 0;
    localparam int WORD  = 1 << LW;
    localparam int BIT_W = (LW > 0) ? LW : 1;
    localparam int ROWS  = (DEPTH + WORD - 1) / WORD;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int QW    = (PW > sbbvm_pkg::OFF_W) ? PW : sbbvm_pkg::OFF_W;

    localparam logic [QW-1:0] DEPTH_Q  = QW'(DEPTH);
    localparam logic [31:0]   DEPTH_32 = 32'(DEPTH);
    localparam logic [QW-1:0] BIT_MASK = QW'(WORD - 1);

    logic [sbbvm_pkg::SIZE_W-1:0] r_buf_size;
    logic [ROWS-1:0]              r_row_vld;
    logic [sbbvm_pkg::CMD_W-1:0]  r_cmd;
    logic [QW-1:0]                r_off;
    logic [sbbvm_pkg::BYTE_W-1:0] r_wbyte;
    logic [ROW_W-1:0]             r_row;

    logic [QW-1:0]                w_size;
    logic [QW-1:0]                w_off_in;
    logic [ROW_W-1:0]             w_off_in_row;
    logic [ROW_W-1:0]             w_off_row;
    logic [BIT_W-1:0]             w_off_bit;
    logic [QW-1:0]                w_last;
    logic [ROW_W-1:0]             w_last_row;
    logic [BIT_W-1:0]             w_last_bit;
    logic [WORD-1:0]              w_vram_q;
    logic [WORD-1:0]              w_word;
    logic [WORD-1:0]              w_set;
    logic [WORD-1:0]              w_mask;
    logic [WORD-1:0]              w_cand;
    logic [BIT_W-1:0]             w_hit_bit;
    logic [QW-1:0]                w_pos;
    logic [ROW_W-1:0]             w_vram_raddr;
    logic [sbbvm_pkg::BYTE_W-1:0] w_bram_q;
    logic                         w_rv;
    logic                         w_want;

    always_comb begin
        if ({{(32 - sbbvm_pkg::SIZE_W){1'b0}}, r_buf_size} > DEPTH_32) begin
            w_size = DEPTH_Q;
        end else begin
            w_size = QW'(r_buf_size);
        end
    end

    assign w_off_in     = QW'(i_offset);
    assign w_off_in_row = ROW_W'(w_off_in >> LW);
    assign w_off_row    = ROW_W'(r_off >> LW);
    assign w_off_bit    = BIT_W'(r_off & BIT_MASK);
    assign w_last       = w_size - QW'(1);
    assign w_last_row   = ROW_W'(w_last >> LW);
    assign w_last_bit   = BIT_W'(w_last & BIT_MASK);

    assign w_word = r_row_vld[r_row] ? w_vram_q : '0;
    assign w_set  = WORD'(1) << w_off_bit;
    assign w_rv   = w_word[w_off_bit];
    assign w_want = (r_cmd == sbbvm_pkg::CMD_NEXT_VALID);

    always_comb begin
        for (int b = 0; b < WORD; b++) begin
            w_mask[b] = ((r_row != w_off_row) || (BIT_W'(b) >= w_off_bit)) &&
                        ((r_row != w_last_row) || (BIT_W'(b) <= w_last_bit));
        end
    end

    assign w_cand = (w_want ? w_word : ~w_word) & w_mask;

    always_comb begin
        w_hit_bit = '0;
        for (int b = WORD - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_hit_bit = BIT_W'(b);
            end
        end
    end

    assign w_pos = (QW'(r_row) << LW) | QW'(w_hit_bit);

    assign o_sts.in_range = (w_off_in < w_size);
    assign o_sts.hit      = |w_cand;
    assign o_sts.last     = (r_row == w_last_row);

    always_comb begin
        if (i_ctl.capture) begin
            w_vram_raddr = w_off_in_row;
        end else if (i_ctl.step) begin
            w_vram_raddr = r_row + ROW_W'(1);
        end else begin
            w_vram_raddr = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= sbbvm_pkg::SIZE_RESET;
            r_row_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_buf_size <= i_cfg_wdata;
                r_row_vld  <= '0;
            end else if (i_ctl.clear_map) begin
                r_row_vld <= '0;
            end else if (i_ctl.wr_commit) begin
                r_row_vld[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_command;
            r_off   <= w_off_in;
            r_wbyte <= i_write_byte;
        end
        r_row <= w_vram_raddr;
    end

    sbbvm_ram #(
        .WIDTH (WORD),
        .DEPTH (ROWS)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_commit),
        .i_waddr (r_row),
        .i_wdata (w_word | w_set),
        .i_raddr (w_vram_raddr),
        .o_rdata (w_vram_q)
    );

    sbbvm_ram #(
        .WIDTH (sbbvm_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_commit),
        .i_waddr (AW'(r_off)),
        .i_wdata (r_wbyte),
        .i_raddr (AW'(w_off_in)),
        .o_rdata (w_bram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (i_ctl.emit != sbbvm_pkg::EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit != sbbvm_pkg::EMIT_NONE) begin
            o_status       <= 1'b0;
            o_found_offset <= '0;
            o_run_length   <= '0;
            o_read_byte    <= '0;
            o_is_valid     <= 1'b0;
            unique case (i_ctl.emit)
                sbbvm_pkg::EMIT_ERR: begin
                    o_status <= 1'b1;
                end
                sbbvm_pkg::EMIT_READ: begin
                    o_is_valid  <= w_rv;
                    o_read_byte <= w_rv ? w_bram_q : '0;
                end
                sbbvm_pkg::EMIT_HIT: begin
                    if (r_cmd == sbbvm_pkg::CMD_RUN_LENGTH) begin
                        o_run_length <= sbbvm_pkg::RES_W'(w_pos - r_off);
                    end else begin
                        o_found_offset <= sbbvm_pkg::RES_W'(w_pos);
                    end
                end
                sbbvm_pkg::EMIT_END: begin
                    if (r_cmd == sbbvm_pkg::CMD_RUN_LENGTH) begin
                        o_run_length <= sbbvm_pkg::RES_W'(w_size - r_off);
                    end else begin
                        o_found_offset <= sbbvm_pkg::RES_W'(DEPTH_Q);
                    end
                end
                sbbvm_pkg::EMIT_OOR: begin
                    if (i_command != sbbvm_pkg::CMD_RUN_LENGTH) begin
                        o_found_offset <= sbbvm_pkg::RES_W'(DEPTH_Q);
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_err_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_found_offset == '0 && o_run_length == '0 &&
                                  o_read_byte == '0 && !o_is_valid))
        else $error("Error word carries payload.");
    a_one_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_found_offset == '0 || o_run_length == '0))
        else $error("Search and run results both set.");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sparse_byte_buffer_valid_map.sv
// Top level of the sparse byte buffer with valid map.
// Depends on sbbvm_pkg, sbbvm_ctrl, sbbvm_dp (and through it sbbvm_ram).
//
//   Channel   Handshake             Word
//   command   start / busy          i_command, i_offset, i_write_byte
//   result    o_done (one cycle)    o_status, o_found_offset, o_run_length,
//                                   o_read_byte, o_is_valid
//   config    i_cfg_we              i_cfg_wdata (buffer size)
//
// Clear, unknown commands and out-of-range words answer one cycle after acceptance.
// Write and read pass through ST_WR or ST_RD before answering. A search steps through
// the valid-map rows, one RAM row per cycle: at most 128 rows with the defaults.
// The valid map is cleared at reset by per-row flags, with no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall the block.
`default_nettype none

module sparse_byte_buffer_valid_map #(
    parameter int DEPTH          = 4096,
    parameter int SCAN_WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [sbbvm_pkg::CMD_W-1:0]  i_command,
    input  wire logic [sbbvm_pkg::OFF_W-1:0]  i_offset,
    input  wire logic [sbbvm_pkg::BYTE_W-1:0] i_write_byte,
    input  wire logic                         i_cfg_we,
    input  wire logic [sbbvm_pkg::SIZE_W-1:0] i_cfg_wdata,
    output logic                              o_done,
    output logic                              o_status,
    output logic [sbbvm_pkg::RES_W-1:0]       o_found_offset,
    output logic [sbbvm_pkg::RES_W-1:0]       o_run_length,
    output logic [sbbvm_pkg::BYTE_W-1:0]      o_read_byte,
    output logic                              o_is_valid
);

    sbbvm_pkg::t_ctl w_ctl;
    sbbvm_pkg::t_sts w_sts;

    sbbvm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_sts     (w_sts),
        .o_busy    (busy),
        .o_ctl     (w_ctl)
    );

    sbbvm_dp #(
        .DEPTH          (DEPTH),
        .SCAN_WORD_BITS (SCAN_WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_command),
        .i_offset       (i_offset),
        .i_write_byte   (i_write_byte),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_found_offset (o_found_offset),
        .o_run_length   (o_run_length),
        .o_read_byte    (o_read_byte),
        .o_is_valid     (o_is_valid)
    );

endmodule

`default_nettype wire

>>> bench/sparse_byte_buffer_valid_map_test.sv
// Self-checking bench for sparse_byte_buffer_valid_map: directed and random command words.
// A queue-fed driver, and a monitor that keeps its own copy of the byte store and valid map.
// Depends on sbbvm_pkg and the sparse_byte_buffer_valid_map RTL.
`default_nettype none

module sparse_byte_buffer_valid_map_test;
    import sbbvm_pkg::*;

    localparam int MAP_DEPTH     = 4096;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 3;
    localparam int TAIL_CYCLES   = 160;
    localparam int QUIET_LIMIT   = 2000;
    localparam int WORD_TARGET   = 1150;
    localparam int IDLE_PERCENT  = 31;
    localparam int STEADY_FIRST  = 500;
    localparam int STEADY_LAST   = 700;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {ITEM_WORD, ITEM_SIZE, ITEM_HOLD} t_item_kind;

    typedef struct {
        t_item_kind        kind;
        logic [CMD_W-1:0]  command;
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] wbyte;
        logic [SIZE_W-1:0] size;
    } t_item;

    typedef struct packed {
        logic              status;
        logic [RES_W-1:0]  found_offset;
        logic [RES_W-1:0]  run_length;
        logic [BYTE_W-1:0] read_byte;
        logic              is_valid;
    } t_answer;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  i_command    = '0;
    logic [OFF_W-1:0]  i_offset     = '0;
    logic [BYTE_W-1:0] i_write_byte = '0;
    logic              i_cfg_we     = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata  = '0;
    logic              o_done;
    logic              o_status;
    logic [RES_W-1:0]  o_found_offset;
    logic [RES_W-1:0]  o_run_length;
    logic [BYTE_W-1:0] o_read_byte;
    logic              o_is_valid;

    t_item   pending_items[$];
    t_answer answers_due[$];
    int      mismatches   = 0;
    int      words_sent   = 0;
    int      results_seen = 0;
    int      settle_count = 0;

    logic [BYTE_W-1:0] model_bytes [MAP_DEPTH];
    bit                model_valid [MAP_DEPTH];
    logic [SIZE_W-1:0] model_size;

    // Offsets that hold a stored byte, so that reads never touch an unwritten entry.
    bit gen_stored [MAP_DEPTH];
    int gen_stored_list[$];
    int gen_limit = MAP_DEPTH;
    int gen_words = 0;

    sparse_byte_buffer_valid_map u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_offset       (i_offset),
        .i_write_byte   (i_write_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_found_offset (o_found_offset),
        .o_run_length   (o_run_length),
        .o_read_byte    (o_read_byte),
        .o_is_valid     (o_is_valid)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int active_limit(logic [SIZE_W-1:0] sz);
        return (sz > MAP_DEPTH) ? MAP_DEPTH : int'(sz);
    endfunction

    function automatic int fit_offset(int x);
        return (x < 0) ? 0 : ((x > MAP_DEPTH - 1) ? MAP_DEPTH - 1 : x);
    endfunction

    function automatic void clear_map();
        foreach (model_valid[i]) model_valid[i] = 1'b0;
    endfunction

    function automatic int scan_map(int from, int lim, bit want);
        int i;
        for (i = from; i < lim; i++) begin
            if (model_valid[i] == want) return i;
        end
        return MAP_DEPTH;
    endfunction

    function automatic t_answer buffer_response(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] off,
                                                logic [BYTE_W-1:0] wbyte);
        t_answer ans;
        int      lim;
        int      hit;
        bit      in_range;
        ans      = '0;
        lim      = active_limit(model_size);
        in_range = int'(off) < lim;
        case (cmd)
            CMD_WRITE: begin
                if (in_range) begin
                    model_bytes[off] = wbyte;
                    model_valid[off] = 1'b1;
                end else begin
                    ans.status = 1'b1;
                end
            end
            CMD_CLEAR: begin
                clear_map();
            end
            CMD_READ: begin
                if (in_range) begin
                    ans.is_valid = model_valid[off];
                    if (model_valid[off]) ans.read_byte = model_bytes[off];
                end else begin
                    ans.status = 1'b1;
                end
            end
            CMD_NEXT_VALID: begin
                ans.found_offset = RES_W'(scan_map(int'(off), lim, 1'b1));
            end
            CMD_NEXT_INVALID: begin
                ans.found_offset = RES_W'(scan_map(int'(off), lim, 1'b0));
            end
            CMD_RUN_LENGTH: begin
                if (in_range) begin
                    hit = scan_map(int'(off), lim, 1'b0);
                    ans.run_length = RES_W'(((hit == MAP_DEPTH) ? lim : hit) - int'(off));
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic compare_field(string label, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_word(logic [CMD_W-1:0] cmd, int off, logic [BYTE_W-1:0] wbyte);
        t_item it;
        it.kind    = ITEM_WORD;
        it.command = cmd;
        it.offset  = OFF_W'(off);
        it.wbyte   = wbyte;
        it.size    = '0;
        pending_items.push_back(it);
        gen_words++;
        if (cmd == CMD_WRITE && off < gen_limit && !gen_stored[off]) begin
            gen_stored[off] = 1'b1;
            gen_stored_list.push_back(off);
        end
    endtask

    task automatic queue_size(logic [SIZE_W-1:0] sz);
        t_item it;
        it.kind    = ITEM_SIZE;
        it.command = CMD_WRITE;
        it.offset  = '0;
        it.wbyte   = '0;
        it.size    = sz;
        pending_items.push_back(it);
        gen_limit = active_limit(sz);
    endtask

    task automatic queue_hold();
        t_item it;
        it.kind    = ITEM_HOLD;
        it.command = CMD_WRITE;
        it.offset  = '0;
        it.wbyte   = '0;
        it.size    = '0;
        pending_items.push_back(it);
    endtask

    function automatic int pick_offset(int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, MAP_DEPTH - 1);
        if (r < 20) return fit_offset(gen_limit - 2 + $urandom_range(0, 4));
        return fit_offset(base + $urandom_range(0, 47));
    endfunction

    always @(posedge i_clk) begin
        logic  taken;
        logic  next_start;
        logic  next_we;
        t_item it;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
            words_sent   = 0;
            settle_count = 0;
        end else begin
            taken      = start && !busy;
            next_start = start && !taken;
            next_we    = 1'b0;
            if (taken) words_sent++;
            if (words_sent == results_seen && !busy && !start && !i_cfg_we) begin
                settle_count++;
            end else begin
                settle_count = 0;
            end
            if (!next_start && !i_cfg_we && pending_items.size() > 0) begin
                it = pending_items[0];
                if (it.kind == ITEM_WORD) begin
                    if ((words_sent >= STEADY_FIRST && words_sent < STEADY_LAST) ||
                        $urandom_range(0, 99) >= IDLE_PERCENT) begin
                        void'(pending_items.pop_front());
                        i_command    <= it.command;
                        i_offset     <= it.offset;
                        i_write_byte <= it.wbyte;
                        next_start = 1'b1;
                    end
                end else if (settle_count >= SETTLE_CYCLES) begin
                    void'(pending_items.pop_front());
                    settle_count = 0;
                    if (it.kind == ITEM_SIZE) begin
                        i_cfg_wdata <= it.size;
                        next_we = 1'b1;
                    end
                end
            end
            start    <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // The result is checked before the word accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            model_size = SIZE_RESET;
            clear_map();
        end else begin
            if (o_done) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result word with no command outstanding", $time);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    compare_field("status", RES_W'(want.status), RES_W'(o_status));
                    compare_field("found_offset", want.found_offset, o_found_offset);
                    compare_field("run_length", want.run_length, o_run_length);
                    compare_field("read_byte", RES_W'(want.read_byte), RES_W'(o_read_byte));
                    compare_field("is_valid", RES_W'(want.is_valid), RES_W'(o_is_valid));
                end
                results_seen <= results_seen + 1;
            end
            if (i_cfg_we) begin
                model_size = i_cfg_wdata;
                clear_map();
            end
            if (start && !busy) begin
                answers_due.push_back(buffer_response(i_command, i_offset, i_write_byte));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int                size_corners[10] = '{0, 1, 2, 31, 32, 33, 4095, 4096, 4097, 8191};
        int                r;
        int                off;
        int                base;
        int                n;
        int                k;
        int                phase_len;
        logic [SIZE_W-1:0] sz;

        queue_word(CMD_NEXT_VALID, 0, 8'h00);
        queue_word(CMD_NEXT_INVALID, 0, 8'h00);
        queue_word(CMD_RUN_LENGTH, 0, 8'h00);
        queue_word(CMD_WRITE, 0, 8'h00);
        queue_word(CMD_WRITE, 4095, 8'hFF);
        queue_word(CMD_WRITE, 1, 8'hA5);
        queue_word(CMD_WRITE, 2, 8'h5A);
        queue_word(CMD_READ, 0, 8'hFF);
        queue_word(CMD_READ, 4095, 8'h00);
        queue_word(CMD_RUN_LENGTH, 0, 8'h00);
        queue_word(CMD_NEXT_VALID, 3, 8'h00);
        queue_word(CMD_NEXT_INVALID, 0, 8'h00);
        queue_word(CMD_NEXT_INVALID, 4095, 8'h00);
        queue_word(CMD_RUN_LENGTH, 4095, 8'h00);
        queue_word(CMD_SPARE_6, 4095, 8'hFF);
        queue_word(CMD_SPARE_7, 0, 8'h00);
        queue_word(CMD_CLEAR, 0, 8'h00);
        queue_word(CMD_READ, 1, 8'h00);
        queue_size(13'd2);
        queue_word(CMD_WRITE, 2, 8'h3C);
        queue_word(CMD_WRITE, 1, 8'hC3);
        queue_word(CMD_READ, 4095, 8'h00);
        queue_word(CMD_NEXT_VALID, 0, 8'h00);
        queue_word(CMD_RUN_LENGTH, 3, 8'h00);
        queue_size(13'd8191);
        queue_word(CMD_WRITE, 4095, 8'h81);
        queue_word(CMD_READ, 4095, 8'h00);
        queue_size(13'd0);
        queue_word(CMD_WRITE, 0, 8'h00);
        queue_word(CMD_READ, 0, 8'h00);
        queue_word(CMD_NEXT_INVALID, 0, 8'h00);
        queue_hold();

        // Small sizes dominate so that runs and searches meet both ends of the map often.
        while (gen_words < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                sz = SIZE_W'(size_corners[$urandom_range(0, 9)]);
            end else if (r < 80) begin
                sz = SIZE_W'($urandom_range(1, 200));
            end else begin
                sz = SIZE_W'($urandom_range(0, 8191));
            end
            queue_size(sz);
            phase_len = $urandom_range(40, 120);
            base = (gen_limit > 48) ? $urandom_range(0, gen_limit - 48) : 0;
            repeat (phase_len) begin
                if (gen_words >= WORD_TARGET) break;
                if ($urandom_range(0, 39) == 0) begin
                    base = (gen_limit > 48) ? $urandom_range(0, gen_limit - 48) : 0;
                end
                off = pick_offset(base);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    n = $urandom_range(4, 24);
                    for (k = 0; k < n; k++) begin
                        queue_word(CMD_WRITE, fit_offset(off + k), BYTE_W'($urandom()));
                    end
                end else if (r < 35) begin
                    queue_word(CMD_WRITE, off, BYTE_W'($urandom()));
                end else if (r < 50 && gen_stored_list.size() > 0) begin
                    queue_word(CMD_READ,
                               gen_stored_list[$urandom_range(0, gen_stored_list.size() - 1)],
                               BYTE_W'($urandom()));
                end else if (r < 62) begin
                    queue_word(CMD_NEXT_VALID, off, BYTE_W'($urandom()));
                end else if (r < 74) begin
                    queue_word(CMD_NEXT_INVALID, off, BYTE_W'($urandom()));
                end else if (r < 90) begin
                    queue_word(CMD_RUN_LENGTH, off, BYTE_W'($urandom()));
                end else if (r < 93) begin
                    queue_word(CMD_CLEAR, off, BYTE_W'($urandom()));
                end else if (r < 96) begin
                    queue_word($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, off,
                               BYTE_W'($urandom()));
                end else begin
                    queue_hold();
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || i_cfg_we || words_sent != results_seen);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, answers_due.size());
        end
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
